[hw/rtl/pksg_pkg.sv]
// ----------------------------------------------------------------------------
// Permutation keystream generator package
// Shared constants, permutation tables and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package pksg_pkg;

   localparam int PKSG_BLOCK_ENTRIES = 32;
   localparam int PKSG_TAB_LEN       = 32;
   localparam int PKSG_MAX_OUT       = 32;
   localparam int PKSG_KEY_BYTES     = 8;

   localparam logic [4:0] PKSG_OUTER_TAB [PKSG_TAB_LEN] = '{
      5'd21, 5'd8,  5'd19, 5'd12, 5'd2,  5'd11, 5'd28, 5'd20,
      5'd7,  5'd5,  5'd9,  5'd1,  5'd22, 5'd27, 5'd16, 5'd31,
      5'd18, 5'd3,  5'd26, 5'd29, 5'd17, 5'd15, 5'd25, 5'd14,
      5'd30, 5'd13, 5'd6,  5'd4,  5'd10, 5'd24, 5'd23, 5'd0
   };

   localparam logic [4:0] PKSG_MIDDLE_TAB [PKSG_TAB_LEN] = '{
      5'd10, 5'd7,  5'd15, 5'd11, 5'd14, 5'd30, 5'd8,  5'd18,
      5'd20, 5'd21, 5'd4,  5'd0,  5'd31, 5'd28, 5'd16, 5'd13,
      5'd24, 5'd23, 5'd27, 5'd9,  5'd12, 5'd22, 5'd6,  5'd3,
      5'd1,  5'd5,  5'd19, 5'd29, 5'd26, 5'd25, 5'd17, 5'd2
   };

   localparam logic [4:0] PKSG_INNER_TAB [PKSG_TAB_LEN] = '{
      5'd31, 5'd11, 5'd4,  5'd17, 5'd27, 5'd9,  5'd26, 5'd8,
      5'd1,  5'd10, 5'd28, 5'd5,  5'd3,  5'd25, 5'd23, 5'd21,
      5'd14, 5'd20, 5'd16, 5'd2,  5'd7,  5'd0,  5'd12, 5'd30,
      5'd29, 5'd22, 5'd18, 5'd13, 5'd6,  5'd19, 5'd24, 5'd15
   };

   localparam logic PKSG_SALT_TAB [PKSG_TAB_LEN] = '{
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };

   typedef struct packed {
      logic start;
      logic reload;
      logic issue;
      logic finish;
   } pksg_cmd_type;

   typedef struct packed {
      logic step;
      logic pipe_empty;
   } pksg_status_type;

endpackage

`default_nettype wire

[hw/rtl/pksg_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module pksg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/pksg_ctrl.sv]
// ----------------------------------------------------------------------------
// Permutation keystream generator controller
// Accepts a request, issues block indexes into the datapath, waits for the
// pipeline to drain and commits the block.
// ----------------------------------------------------------------------------
`default_nettype none

module pksg_ctrl
   import pksg_pkg::*;
#(
   parameter int BLOCK_ENTRIES = PKSG_BLOCK_ENTRIES,
   localparam int IDX_W        = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_reload,
   input  wire pksg_status_type status,
   output pksg_cmd_type         cmd,
   output logic [IDX_W-1:0]     issue_idx
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.reload = req_reload;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.step) begin
               if (idx_ff == IDX_W'(BLOCK_ENTRIES - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign issue_idx = idx_ff;

endmodule

`default_nettype wire

[hw/rtl/pksg_datapath.sv]
// ----------------------------------------------------------------------------
// Permutation keystream generator datapath
// Three-stage pipeline: middle table read, composition and salt reads,
// salt update with forwarding, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pksg_datapath
   import pksg_pkg::*;
#(
   parameter int BLOCK_ENTRIES = PKSG_BLOCK_ENTRIES,
   localparam int IDX_W        = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [63:0]      csr_write_data,
   input  wire pksg_cmd_type     cmd,
   input  wire logic [IDX_W-1:0] issue_idx,
   output pksg_status_type       status,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_byte_value,
   output logic [4:0]            rsp_byte_index,
   output logic                  rsp_last_byte
);

   logic [IDX_W-1:0] outer_tab  [BLOCK_ENTRIES];
   logic [IDX_W-1:0] inner_tab  [BLOCK_ENTRIES];
   logic [IDX_W-1:0] middle_tab [BLOCK_ENTRIES];
   logic [7:0]       salt_init  [BLOCK_ENTRIES];

   logic [63:0]      seed_key_ff;
   logic [63:0]      seed_key_in;
   logic [63:0]      init_key_ff;
   logic [63:0]      init_key_in;
   logic             fresh_ff;
   logic             fresh_in;
   logic             bank_ff;
   logic             bank_in;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [IDX_W-1:0] s1_idx_in;
   logic [IDX_W-1:0] s1_inner_ff;
   logic [IDX_W-1:0] s1_inner_in;
   logic             s2_valid_ff;
   logic             s2_valid_in;
   logic [IDX_W-1:0] s2_idx_ff;
   logic [IDX_W-1:0] s2_idx_in;
   logic [IDX_W-1:0] s2_comp_ff;
   logic [IDX_W-1:0] s2_comp_in;
   logic [7:0]       prev_res_ff;
   logic [7:0]       prev_res_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       rsp_value_ff;
   logic [7:0]       rsp_value_in;
   logic [4:0]       rsp_index_ff;
   logic [4:0]       rsp_index_in;
   logic             rsp_last_ff;
   logic             rsp_last_in;

   logic             step;
   logic [IDX_W-1:0] mid_rd_data;
   logic [IDX_W-1:0] mid_sel;
   logic [IDX_W-1:0] comp1;
   logic [7:0]       salt_a_rd;
   logic [7:0]       salt_b_rd;
   logic [7:0]       own_val;
   logic [7:0]       other_val;
   logic [7:0]       res;
   logic [31:0]      idx32;
   logic             emit;
   logic             salt_wr_en;

   for (genvar g = 0; g < BLOCK_ENTRIES; g++) begin : g_tab
      assign outer_tab[g]  = IDX_W'(PKSG_OUTER_TAB[g % PKSG_TAB_LEN] % BLOCK_ENTRIES);
      assign inner_tab[g]  = IDX_W'(PKSG_INNER_TAB[g % PKSG_TAB_LEN] % BLOCK_ENTRIES);
      assign middle_tab[g] = IDX_W'(PKSG_MIDDLE_TAB[g % PKSG_TAB_LEN] % BLOCK_ENTRIES);
      if (g < PKSG_KEY_BYTES) begin : g_key
         assign salt_init[g] = {7'd0, PKSG_SALT_TAB[g % PKSG_TAB_LEN]} ^ init_key_ff[8*g +: 8];
      end else begin : g_plain
         assign salt_init[g] = {7'd0, PKSG_SALT_TAB[g % PKSG_TAB_LEN]};
      end
   end

   assign step              = !rsp_valid_ff || rsp_ready;
   assign status.step       = step;
   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff;

   pksg_ram #(
      .WIDTH (IDX_W),
      .DEPTH (2 << IDX_W)
   ) u_mid_ram (
      .clock   (clock),
      .wr_en   (step && s1_valid_ff),
      .wr_addr ({~bank_ff, s1_idx_ff}),
      .wr_data (comp1),
      .rd_en   (step),
      .rd_addr ({bank_ff, inner_tab[issue_idx]}),
      .rd_data (mid_rd_data)
   );

   pksg_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_ENTRIES)
   ) u_salt_a_ram (
      .clock   (clock),
      .wr_en   (salt_wr_en),
      .wr_addr (s2_idx_ff),
      .wr_data (res),
      .rd_en   (step),
      .rd_addr (s1_idx_ff),
      .rd_data (salt_a_rd)
   );

   pksg_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_ENTRIES)
   ) u_salt_b_ram (
      .clock   (clock),
      .wr_en   (salt_wr_en),
      .wr_addr (s2_idx_ff),
      .wr_data (res),
      .rd_en   (step),
      .rd_addr (comp1),
      .rd_data (salt_b_rd)
   );

   always_comb begin
      mid_sel = fresh_ff ? middle_tab[s1_inner_ff] : mid_rd_data;
      comp1   = outer_tab[mid_sel];

      own_val = fresh_ff ? salt_init[s2_idx_ff] : salt_a_rd;
      if (s2_comp_ff == s2_idx_ff) begin
         other_val = own_val;
      end else if (s2_comp_ff < s2_idx_ff) begin
         other_val = (s2_comp_ff == s2_idx_ff - IDX_W'(1)) ? prev_res_ff : salt_b_rd;
      end else begin
         other_val = fresh_ff ? salt_init[s2_comp_ff] : salt_b_rd;
      end
      res = own_val ^ other_val;

      salt_wr_en = step && s2_valid_ff;
      idx32      = 32'(s2_idx_ff);
      emit       = s2_valid_ff && (idx32 < 32'(PKSG_MAX_OUT));
   end

   always_comb begin
      seed_key_in = csr_write_enable ? csr_write_data : seed_key_ff;
      init_key_in = init_key_ff;
      fresh_in    = fresh_ff;
      bank_in     = bank_ff;
      if (cmd.start) begin
         fresh_in = fresh_ff || cmd.reload;
         if (cmd.reload) begin
            init_key_in = seed_key_ff;
         end
      end
      if (cmd.finish) begin
         fresh_in = 1'b0;
         bank_in  = ~bank_ff;
      end

      s1_valid_in  = s1_valid_ff;
      s1_idx_in    = s1_idx_ff;
      s1_inner_in  = s1_inner_ff;
      s2_valid_in  = s2_valid_ff;
      s2_idx_in    = s2_idx_ff;
      s2_comp_in   = s2_comp_ff;
      prev_res_in  = prev_res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      if (step) begin
         s1_valid_in  = cmd.issue;
         s1_idx_in    = issue_idx;
         s1_inner_in  = inner_tab[issue_idx];
         s2_valid_in  = s1_valid_ff;
         s2_idx_in    = s1_idx_ff;
         s2_comp_in   = comp1;
         prev_res_in  = res;
         rsp_valid_in = emit;
         rsp_value_in = res;
         rsp_index_in = idx32[4:0];
         rsp_last_in  = (idx32 == 32'(BLOCK_ENTRIES - 1)) ||
                        (idx32 == 32'(PKSG_MAX_OUT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_key_ff  <= '0;
         init_key_ff  <= '0;
         fresh_ff     <= 1'b1;
         bank_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_key_ff  <= seed_key_in;
         init_key_ff  <= init_key_in;
         fresh_ff     <= fresh_in;
         bank_ff      <= bank_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= s1_idx_in;
      s1_inner_ff  <= s1_inner_in;
      s2_idx_ff    <= s2_idx_in;
      s2_comp_ff   <= s2_comp_in;
      prev_res_ff  <= prev_res_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_value = rsp_value_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_last_byte  = rsp_last_ff;

endmodule

`default_nettype wire

[hw/rtl/permutation_keystream_generator_top.sv]
// ----------------------------------------------------------------------------
// Permutation keystream generator
// Each request yields one block of salt bytes; one transfer per byte, the
// first 32 bytes of a block, in index order, the last one flagged.
// ----------------------------------------------------------------------------
// A request is accepted, then one block index is issued per cycle while
// the result channel does not stall, through a three-stage pipeline;
// the pipeline then drains and the block is committed; only then can the
// next request be taken. The salt update loop writes one salt entry per
// cycle while the result channel does not stall, through a single write
// port, and forwards the entry written just before it. Results leave one
// per cycle while the result channel is ready. Reload and the state after
// reset are applied on the fly from the built-in tables: no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_keystream_generator_top
   import pksg_pkg::*;
#(
   parameter int BLOCK_ENTRIES = PKSG_BLOCK_ENTRIES,
   localparam int IDX_W        = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [63:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_reload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_byte_value,
   output logic [4:0]       rsp_byte_index,
   output logic             rsp_last_byte
);

   pksg_cmd_type     cmd;
   pksg_status_type  status;
   logic [IDX_W-1:0] issue_idx;

   pksg_ctrl #(
      .BLOCK_ENTRIES (BLOCK_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_reload (req_reload),
      .status     (status),
      .cmd        (cmd),
      .issue_idx  (issue_idx)
   );

   pksg_datapath #(
      .BLOCK_ENTRIES (BLOCK_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .issue_idx        (issue_idx),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte)
   );

endmodule

`default_nettype wire
